### hw/rtl/ketsr_pkg.sv
// ============================================================================
// ketsr_pkg
// Shared types and constants for the keyed entry table with swap-remove.
// ============================================================================
package ketsr_pkg;

    localparam int CAPACITY = 16;
    localparam int ADDR_W   = $clog2(CAPACITY);

    localparam int VALUE_W  = 64;
    localparam int SLOT_W   = 5;
    localparam int COUNT_W  = 5;
    localparam int REQ_W    = 2;
    localparam int STATUS_W = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT = 2'd0,
        REQ_READ   = 2'd1,
        REQ_DELETE = 2'd2,
        REQ_NONE   = 2'd3
    } req_type_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_BADIDX   = 2'd3
    } status_t;

    typedef struct packed {
        logic               en;
        logic [ADDR_W-1:0]  addr;
        logic [VALUE_W-1:0] data;
    } store_wr_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } store_rd_t;

endpackage

### hw/rtl/ketsr_if.sv
// ============================================================================
// ketsr_if
// Valid/ready channels for request and response transactions.
// ============================================================================
interface ketsr_req_if
    import ketsr_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [REQ_W-1:0]   req_type;
    logic [VALUE_W-1:0] entry_value;
    logic [SLOT_W-1:0]  slot_index;

    modport source (output valid, req_type, entry_value, slot_index, input ready);
    modport sink   (input valid, req_type, entry_value, slot_index, output ready);
endinterface

interface ketsr_rsp_if
    import ketsr_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [VALUE_W-1:0]  read_value;
    logic [COUNT_W-1:0]  live_count;
    logic [STATUS_W-1:0] status;

    modport source (output valid, read_value, live_count, status, input ready);
    modport sink   (input valid, read_value, live_count, status, output ready);
endinterface

### hw/rtl/keyed_entry_table_swap_remove.sv
// ============================================================================
// keyed_entry_table_swap_remove
// Table of 64-bit entries with append, indexed read and swap-remove delete.
//
//   channel  role  fields
//   req      sink  req_type, entry_value, slot_index
//   rsp      src   read_value, live_count, status
//
// One request at a time; each gives one response transaction.
// Insert, ignored and rejected requests go from idle straight to done, read
// passes through S_READ, delete scans entries through the single read port.
// Reset clears state, count and output valid; store contents are undefined until written.
// A new request is taken while a response still waits in the output register;
// completion then holds until that response is taken.
// ============================================================================
module keyed_entry_table_swap_remove
    import ketsr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    ketsr_req_if.sink   req,
    ketsr_rsp_if.source rsp
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_SCAN = 5'b00100,
        S_MOVE = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    localparam logic [COUNT_W-1:0] CAP_COUNT = COUNT_W'(CAPACITY);

    state_t              state_reg, state_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [VALUE_W-1:0]  key_reg, key_next;
    logic [ADDR_W-1:0]   scan_reg, scan_next;
    logic [VALUE_W-1:0]  res_value_reg, res_value_next;
    status_t             res_status_reg, res_status_next;

    logic                out_valid_reg;
    logic [VALUE_W-1:0]  out_value_reg;
    logic [COUNT_W-1:0]  out_count_reg;
    logic [STATUS_W-1:0] out_status_reg;

    store_wr_t           st_wr;
    store_rd_t           st_rd;
    logic [VALUE_W-1:0]  rd_data;

    logic [ADDR_W-1:0]   slot_m1;
    logic [COUNT_W-1:0]  count_m1;
    logic [ADDR_W-1:0]   last_addr;
    logic                out_load;

    ketsr_store u_store (
        .clk     (clk),
        .wr      (st_wr),
        .rd      (st_rd),
        .rd_data (rd_data)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign slot_m1   = req.slot_index[ADDR_W-1:0] - ADDR_W'(1);
    assign count_m1  = count_reg - COUNT_W'(1);
    assign last_addr = count_m1[ADDR_W-1:0];
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || rsp.ready);

    // Store accesses never overlap: every write lands before the next request
    // can issue a read (S_DONE lies between), so no forwarding is needed.
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        key_next        = key_reg;
        scan_next       = scan_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        st_wr           = '0;
        st_rd           = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    key_next        = req.entry_value;
                    res_value_next  = '0;
                    res_status_next = ST_OK;
                    state_next      = S_DONE;
                    unique case (req_type_t'(req.req_type))
                        REQ_INSERT:
                        begin
                            if (count_reg >= CAP_COUNT)
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                st_wr.en   = 1'b1;
                                st_wr.addr = count_reg[ADDR_W-1:0];
                                st_wr.data = req.entry_value;
                                count_next = count_reg + COUNT_W'(1);
                            end
                        end
                        REQ_READ:
                        begin
                            if (req.slot_index == '0 || req.slot_index > count_reg)
                            begin
                                res_status_next = ST_BADIDX;
                            end
                            else
                            begin
                                st_rd.en   = 1'b1;
                                st_rd.addr = slot_m1;
                                state_next = S_READ;
                            end
                        end
                        REQ_DELETE:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = ST_NOTFOUND;
                            end
                            else
                            begin
                                st_rd.en   = 1'b1;
                                st_rd.addr = '0;
                                scan_next  = '0;
                                state_next = S_SCAN;
                            end
                        end
                        REQ_NONE:
                        begin
                        end
                    endcase
                end
            end
            S_READ:
            begin
                res_value_next = rd_data;
                state_next     = S_DONE;
            end
            S_SCAN:
            begin
                if (rd_data == key_reg)
                begin
                    st_rd.en   = 1'b1;
                    st_rd.addr = last_addr;
                    state_next = S_MOVE;
                end
                else if (scan_reg == last_addr)
                begin
                    res_status_next = ST_NOTFOUND;
                    state_next      = S_DONE;
                end
                else
                begin
                    scan_next  = scan_reg + ADDR_W'(1);
                    st_rd.en   = 1'b1;
                    st_rd.addr = scan_reg + ADDR_W'(1);
                end
            end
            S_MOVE:
            begin
                st_wr.en   = 1'b1;
                st_wr.addr = scan_reg;
                st_wr.data = rd_data;
                count_next = count_m1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg        <= key_next;
        scan_reg       <= scan_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        if (out_load)
        begin
            out_value_reg  <= res_value_reg;
            out_count_reg  <= count_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.read_value = out_value_reg;
    assign rsp.live_count = out_count_reg;
    assign rsp.status     = out_status_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_COUNT)
        else $error("live count above capacity");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != $past(count_reg) |->
            (count_reg == $past(count_reg) + COUNT_W'(1) ||
             count_reg == $past(count_reg) - COUNT_W'(1)))
        else $error("live count moved by more than one");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN || state_reg == S_MOVE) |->
            ({1'b0, scan_reg} < {1'b0, count_reg}))
        else $error("scan beyond live entries");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && res_status_reg == ST_FULL |=> out_count_reg == CAP_COUNT)
        else $error("full status with room left");
`endif

endmodule

### hw/rtl/ketsr_store.sv
// ============================================================================
// ketsr_store
// Entry store: one write port, one read port with registered read data.
// ============================================================================
module ketsr_store
    import ketsr_pkg::*;
(
    input  logic               clk,
    input  store_wr_t          wr,
    input  store_rd_t          rd,
    output logic [VALUE_W-1:0] rd_data
);

    logic [VALUE_W-1:0] mem [CAPACITY];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data <= mem[rd.addr];
        end
    end

endmodule
